// ===== design/clint_pkg.sv =====
// package for the core-local timer: action codes, register offsets and widths
`timescale 1ns / 1ps
`default_nettype none

package clint_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned ACTION_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    localparam logic [OFFSET_W-1:0] OFF_SOFT    = 16'h0000;
    localparam logic [OFFSET_W-1:0] OFF_COMPARE = 16'h4000;
    localparam logic [OFFSET_W-1:0] OFF_TIME    = 16'hBFF8;

    localparam logic [DATA_W-1:0] HIGH_HALF = 64'hFFFF_FFFF_0000_0000;
    localparam logic [DATA_W-1:0] TICK_STEP = 64'h1;

endpackage

`default_nettype wire

// ===== design/clint_req_if.sv =====
// request channel: bus reads, bus writes and time ticks
`timescale 1ns / 1ps
`default_nettype none

interface clint_req_if;

    logic                                valid;
    logic                                ready;
    logic [clint_pkg::ACTION_W-1:0]      action;
    logic [clint_pkg::OFFSET_W-1:0]      offset;
    logic                                size_is_eight;
    logic [clint_pkg::DATA_W-1:0]        write_data;

    modport source (
        output valid,
        output action,
        output offset,
        output size_is_eight,
        output write_data,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  offset,
        input  size_is_eight,
        input  write_data,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/clint_rsp_if.sv =====
// response channel: read data and interrupt pending flags
`timescale 1ns / 1ps
`default_nettype none

interface clint_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [clint_pkg::DATA_W-1:0]      read_data;
    logic                              timer_pending;
    logic                              software_pending;

    modport source (
        output valid,
        output read_data,
        output timer_pending,
        output software_pending,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_data,
        input  timer_pending,
        input  software_pending,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/core_local_timer_interruptor.sv =====
// top level of the core-local timer and software interrupt block
`timescale 1ns / 1ps
`default_nettype none

// Machine timer and software interrupt block. Each request word is a bus read,
// a bus write or one time tick, and each gives exactly one response word with
// the read data and the timer and software pending flags as they stand after
// that request. One request is taken every clock cycle while the response
// output is not stalled; each request passes through the input register and
// then the response register, around the single 64-bit increment and compare.
// The input register lets the block take a new request while a response still
// waits to be taken. Reads at undecoded offsets return zero and writes to them
// are dropped; a 4-byte write to the time register is dropped.
module core_local_timer_interruptor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    clint_req_if.sink       req,
    clint_rsp_if.source     rsp
);

    logic                                s1_valid_reg;
    logic [clint_pkg::ACTION_W-1:0]      s1_action_reg;
    logic [clint_pkg::OFFSET_W-1:0]      s1_offset_reg;
    logic                                s1_wide_reg;
    logic [clint_pkg::DATA_W-1:0]        s1_data_reg;

    logic [clint_pkg::DATA_W-1:0]        time_reg;
    logic [clint_pkg::DATA_W-1:0]        time_next;
    logic [clint_pkg::DATA_W-1:0]        compare_reg;
    logic [clint_pkg::DATA_W-1:0]        compare_next;
    logic [clint_pkg::HALF_W-1:0]        soft_reg;
    logic [clint_pkg::HALF_W-1:0]        soft_next;

    logic                                out_valid_reg;
    logic [clint_pkg::DATA_W-1:0]        read_data_reg;
    logic [clint_pkg::DATA_W-1:0]        read_data_next;
    logic                                timer_pending_reg;
    logic                                timer_pending_next;
    logic                                software_pending_reg;

    logic                                advance;
    logic                                req_ready;
    logic                                step;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req_ready = !s1_valid_reg || advance;
    assign step      = s1_valid_reg && advance;

    assign req.ready            = req_ready;
    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = read_data_reg;
    assign rsp.timer_pending    = timer_pending_reg;
    assign rsp.software_pending = software_pending_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req.valid)
        begin
            s1_action_reg <= req.action;
            s1_offset_reg <= req.offset;
            s1_wide_reg   <= req.size_is_eight;
            s1_data_reg   <= req.write_data;
        end
    end

    // register file update and read mux
    always_comb
    begin
        time_next      = time_reg;
        compare_next   = compare_reg;
        soft_next      = soft_reg;
        read_data_next = '0;
        case (s1_action_reg)
            clint_pkg::ACT_TICK:
            begin
                time_next = time_reg + clint_pkg::TICK_STEP;
            end
            clint_pkg::ACT_WRITE:
            begin
                if (s1_offset_reg == clint_pkg::OFF_SOFT)
                begin
                    soft_next = s1_data_reg[clint_pkg::HALF_W-1:0];
                end
                else if (s1_offset_reg == clint_pkg::OFF_COMPARE)
                begin
                    if (s1_wide_reg)
                    begin
                        compare_next = s1_data_reg;
                    end
                    else
                    begin
                        compare_next = (compare_reg & clint_pkg::HIGH_HALF)
                                     | (s1_data_reg & ~clint_pkg::HIGH_HALF);
                    end
                end
                else if (s1_offset_reg == clint_pkg::OFF_TIME)
                begin
                    if (s1_wide_reg)
                    begin
                        time_next = s1_data_reg;
                    end
                end
            end
            clint_pkg::ACT_READ:
            begin
                if (s1_offset_reg == clint_pkg::OFF_SOFT)
                begin
                    read_data_next = {{(clint_pkg::DATA_W-clint_pkg::HALF_W){1'b0}}, soft_reg};
                end
                else if (s1_offset_reg == clint_pkg::OFF_COMPARE)
                begin
                    read_data_next = s1_wide_reg ? compare_reg
                                                 : (compare_reg & ~clint_pkg::HIGH_HALF);
                end
                else if (s1_offset_reg == clint_pkg::OFF_TIME)
                begin
                    read_data_next = s1_wide_reg ? time_reg
                                                 : (time_reg & ~clint_pkg::HIGH_HALF);
                end
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase
        timer_pending_next = (time_next >= compare_next) && (compare_next != '0);
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= '0;
            compare_reg <= '0;
            soft_reg    <= '0;
        end
        else if (step)
        begin
            time_reg    <= time_next;
            compare_reg <= compare_next;
            soft_reg    <= soft_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            read_data_reg        <= read_data_next;
            timer_pending_reg    <= timer_pending_next;
            software_pending_reg <= soft_next[0];
        end
    end

`ifndef SYNTHESIS
    a_timer_flag_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (timer_pending_reg ==
                           ((time_reg >= compare_reg) && (compare_reg != '0))))
        else $error("timer pending flag disagrees with held state");

    a_soft_flag_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (software_pending_reg == soft_reg[0]))
        else $error("software pending flag disagrees with held state");

    a_response_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("response word appeared without a request in flight");

    a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(time_reg) && $stable(compare_reg)
                                           && $stable(soft_reg)))
        else $error("state changed while response stalled");
`endif

endmodule

`default_nettype wire
